/* rtl/core/nfa_pkg.sv */
`default_nettype none
package nfa_pkg;

    localparam int ADDR_W      = 12;
    localparam int HEAP_UNITS  = 4096;
    localparam int GROW_CHUNK  = 256;
    localparam int UNIT_BYTES  = 4;
    localparam int UNITS_W     = 15;
    localparam int AMOUNT_W    = 16;
    localparam int TOP_W       = 17;
    localparam int STEP_W      = 15;
    localparam int WALK_LIMIT  = 4 * HEAP_UNITS + 16;

    localparam logic [ADDR_W-1:0] LIMIT_RESET = 12'd4095;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic STAT_DONE = 1'b0;
    localparam logic STAT_OOM  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_A_GETP,
        ST_A_CHK,
        ST_A_CARVE,
        ST_A_GROW,
        ST_L_WALK,
        ST_L_M1,
        ST_L_M2,
        ST_L_M3,
        ST_L_RET
    } state_t;

endpackage
`default_nettype wire

/* rtl/core/nfa_ram.sv */
`default_nettype none
module nfa_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 12
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

/* rtl/core/next_fit_free_list_allocator.sv */
// An allocate walks the free ring from the rover one entry at a time and returns on an exact
// fit or after carving the tail; a growth of the break links the new chunk in with a second
// walk and then searches again, or returns at once when refused.
// A free walks the ring to the insertion point, then merges. One item at a time, busy high meanwhile;
// busy falls together with done, and the next item may be taken while done is high. The receiver cannot stall.
// Reset clears control state only; header memories are undefined until written.
`default_nettype none
module next_fit_free_list_allocator
    import nfa_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    output logic                   busy,
    input  wire logic              action,
    input  wire logic [15:0]       byte_count,
    input  wire logic [ADDR_W-1:0] block_address,
    output logic                   done,
    output logic      [ADDR_W-1:0] data_address,
    output logic                   status,
    input  wire logic              cfg_we,
    input  wire logic [ADDR_W-1:0] cfg_wdata
);

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  rover_reg, rover_next;
    logic               started_reg, started_next;
    logic [ADDR_W-1:0]  brk_reg, brk_next;
    logic [ADDR_W-1:0]  limit_reg;
    logic               act_reg, act_next;
    logic [UNITS_W-1:0] units_reg, units_next;
    logic [ADDR_W-1:0]  q_reg, q_next;
    logic [ADDR_W-1:0]  p_reg, p_next;
    logic [ADDR_W:0]    pc_reg, pc_next;
    logic [ADDR_W-1:0]  hdr_reg, hdr_next;
    logic [ADDR_W-1:0]  qn_reg, qn_next;
    logic [ADDR_W-1:0]  szqn_reg, szqn_next;
    logic [ADDR_W-1:0]  nqn_reg, nqn_next;
    logic [ADDR_W-1:0]  newsz_reg, newsz_next;
    logic [ADDR_W-1:0]  pn_reg, pn_next;
    logic [STEP_W-1:0]  steps_reg, steps_next;
    logic [STEP_W-1:0]  lsteps_reg, lsteps_next;
    logic               grow_reg, grow_next;
    logic               done_reg, done_next;
    logic [ADDR_W-1:0]  daddr_reg, daddr_next;
    logic               stat_reg, stat_next;

    // memory ports
    logic              nx_we, sz_we;
    logic [ADDR_W-1:0] nx_waddr, sz_waddr, nx_wdata, sz_wdata;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] nxt_rd, siz_rd;

    nfa_ram #(.DEPTH(HEAP_UNITS), .WIDTH(ADDR_W)) u_next_mem (
        .clk   (clk),
        .we    (nx_we),
        .waddr (nx_waddr),
        .wdata (nx_wdata),
        .raddr (raddr),
        .rdata (nxt_rd)
    );

    nfa_ram #(.DEPTH(HEAP_UNITS), .WIDTH(ADDR_W)) u_size_mem (
        .clk   (clk),
        .we    (sz_we),
        .waddr (sz_waddr),
        .wdata (sz_wdata),
        .raddr (raddr),
        .rdata (siz_rd)
    );

    // request size in units, header included
    logic [16:0]        bytes_rnd;
    logic [UNITS_W-1:0] units_in;
    assign bytes_rnd = {1'b0, byte_count} + 17'(UNIT_BYTES - 1);
    assign units_in  = UNITS_W'(bytes_rnd / UNIT_BYTES) + UNITS_W'(1);

    // fit test and tail carve
    logic              fit, exact;
    logic [ADDR_W-1:0] carve_sz;
    logic [ADDR_W:0]   pc_sum;
    assign fit      = {{(UNITS_W-ADDR_W){1'b0}}, siz_rd} >= units_reg;
    assign exact    = {{(UNITS_W-ADDR_W){1'b0}}, siz_rd} == units_reg;
    assign carve_sz = siz_rd - units_reg[ADDR_W-1:0];
    assign pc_sum   = {1'b0, p_reg} + {1'b0, carve_sz};

    // growth in whole chunks
    logic [AMOUNT_W-1:0] units_rnd, amount;
    logic [TOP_W-1:0]    top;
    logic                refuse;
    assign units_rnd = {1'b0, units_reg} + AMOUNT_W'(GROW_CHUNK - 1);
    assign amount    = AMOUNT_W'((units_rnd / GROW_CHUNK) * GROW_CHUNK);
    assign top       = {{(TOP_W-ADDR_W){1'b0}}, brk_reg} + {1'b0, amount};
    assign refuse    = (top > {{(TOP_W-ADDR_W){1'b0}}, limit_reg})
                    || (top > TOP_W'(HEAP_UNITS));

    // insertion point test for the link walk
    logic found;
    assign found = ((hdr_reg > q_reg) && (hdr_reg < nxt_rd))
                || ((q_reg >= nxt_rd) && ((hdr_reg > q_reg) || (hdr_reg < nxt_rd)));

    // merge tests
    logic              merge_up, merge_dn;
    logic [ADDR_W-1:0] newsz_c, pn_c;
    assign merge_up = ({1'b0, hdr_reg} + {1'b0, siz_rd}) == {1'b0, qn_reg};
    assign newsz_c  = merge_up ? (siz_rd + szqn_reg) : siz_rd;
    assign pn_c     = merge_up ? nqn_reg : qn_reg;
    assign merge_dn = ({1'b0, q_reg} + {1'b0, siz_rd}) == {1'b0, hdr_reg};

    logic [STEP_W-1:0] steps_inc, lsteps_inc;
    assign steps_inc  = steps_reg + STEP_W'(1);
    assign lsteps_inc = lsteps_reg + STEP_W'(1);

    // next state and register updates
    always_comb
    begin
        state_next   = state_reg;
        rover_next   = rover_reg;
        started_next = started_reg;
        brk_next     = brk_reg;
        act_next     = act_reg;
        units_next   = units_reg;
        q_next       = q_reg;
        p_next       = p_reg;
        pc_next      = pc_reg;
        hdr_next     = hdr_reg;
        qn_next      = qn_reg;
        szqn_next    = szqn_reg;
        nqn_next     = nqn_reg;
        newsz_next   = newsz_reg;
        pn_next      = pn_reg;
        steps_next   = steps_reg;
        lsteps_next  = lsteps_reg;
        grow_next    = grow_reg;
        done_next    = 1'b0;
        daddr_next   = daddr_reg;
        stat_next    = stat_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    act_next   = action;
                    units_next = units_in;
                    hdr_next   = block_address - ADDR_W'(1);
                    if (!started_reg)
                    begin
                        rover_next   = '0;
                        started_next = 1'b1;
                    end
                    state_next = ST_START;
                end
            end
            ST_START:
            begin
                q_next      = rover_reg;
                steps_next  = '0;
                lsteps_next = '0;
                grow_next   = 1'b0;
                state_next  = (act_reg == ACT_FREE) ? ST_L_WALK : ST_A_GETP;
            end
            ST_A_GETP:
            begin
                p_next     = nxt_rd;
                state_next = ST_A_CHK;
            end
            ST_A_CHK:
            begin
                if (fit)
                begin
                    rover_next = q_reg;
                    if (exact)
                    begin
                        done_next  = 1'b1;
                        daddr_next = p_reg + ADDR_W'(1);
                        stat_next  = STAT_DONE;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        pc_next    = pc_sum;
                        state_next = ST_A_CARVE;
                    end
                end
                else if (p_reg == rover_reg)
                begin
                    state_next = ST_A_GROW;
                end
                else if (32'(steps_inc) > 32'(WALK_LIMIT))
                begin
                    done_next  = 1'b1;
                    daddr_next = '0;
                    stat_next  = STAT_OOM;
                    state_next = ST_IDLE;
                end
                else
                begin
                    q_next     = p_reg;
                    p_next     = nxt_rd;
                    steps_next = steps_inc;
                end
            end
            ST_A_CARVE:
            begin
                done_next  = 1'b1;
                daddr_next = pc_reg[ADDR_W-1:0] + ADDR_W'(1);
                stat_next  = STAT_DONE;
                state_next = ST_IDLE;
            end
            ST_A_GROW:
            begin
                if (refuse)
                begin
                    done_next  = 1'b1;
                    daddr_next = '0;
                    stat_next  = STAT_OOM;
                    state_next = ST_IDLE;
                end
                else
                begin
                    hdr_next    = brk_reg;
                    brk_next    = top[ADDR_W-1:0];
                    q_next      = rover_reg;
                    lsteps_next = '0;
                    grow_next   = 1'b1;
                    state_next  = ST_L_WALK;
                end
            end
            ST_L_WALK:
            begin
                if (found)
                begin
                    qn_next    = nxt_rd;
                    state_next = ST_L_M1;
                end
                else if (32'(lsteps_inc) > 32'(WALK_LIMIT))
                begin
                    state_next = ST_L_RET;
                end
                else
                begin
                    q_next      = nxt_rd;
                    lsteps_next = lsteps_inc;
                end
            end
            ST_L_M1:
            begin
                szqn_next  = siz_rd;
                nqn_next   = nxt_rd;
                state_next = ST_L_M2;
            end
            ST_L_M2:
            begin
                newsz_next = newsz_c;
                pn_next    = pn_c;
                state_next = ST_L_M3;
            end
            ST_L_M3:
            begin
                rover_next = q_reg;
                state_next = ST_L_RET;
            end
            ST_L_RET:
            begin
                if (!grow_reg)
                begin
                    done_next  = 1'b1;
                    daddr_next = '0;
                    stat_next  = STAT_DONE;
                    state_next = ST_IDLE;
                end
                else if (32'(steps_inc) > 32'(WALK_LIMIT))
                begin
                    done_next  = 1'b1;
                    daddr_next = '0;
                    stat_next  = STAT_OOM;
                    state_next = ST_IDLE;
                end
                else
                begin
                    steps_next = steps_inc;
                    q_next     = rover_reg;
                    state_next = ST_A_GETP;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // memory reads and writes
    always_comb
    begin
        nx_we    = 1'b0;
        nx_waddr = '0;
        nx_wdata = '0;
        sz_we    = 1'b0;
        sz_waddr = '0;
        sz_wdata = '0;
        raddr    = q_reg;
        case (state_reg)
            ST_IDLE:
            begin
                // base header links to itself on first use
                if (start && !started_reg)
                begin
                    nx_we = 1'b1;
                    sz_we = 1'b1;
                end
            end
            ST_START:
            begin
                raddr = rover_reg;
            end
            ST_A_GETP:
            begin
                raddr = nxt_rd;
            end
            ST_A_CHK:
            begin
                raddr = nxt_rd;
                if (fit && exact)
                begin
                    nx_we    = 1'b1;
                    nx_waddr = q_reg;
                    nx_wdata = nxt_rd;
                end
                else if (fit)
                begin
                    sz_we    = 1'b1;
                    sz_waddr = p_reg;
                    sz_wdata = carve_sz;
                end
            end
            ST_A_CARVE:
            begin
                if (!pc_reg[ADDR_W])
                begin
                    sz_we    = 1'b1;
                    sz_waddr = pc_reg[ADDR_W-1:0];
                    sz_wdata = units_reg[ADDR_W-1:0];
                end
            end
            ST_A_GROW:
            begin
                raddr = rover_reg;
                if (!refuse)
                begin
                    sz_we    = 1'b1;
                    sz_waddr = brk_reg;
                    sz_wdata = amount[ADDR_W-1:0];
                end
            end
            ST_L_WALK:
            begin
                raddr = nxt_rd;
            end
            ST_L_M1:
            begin
                raddr = hdr_reg;
            end
            ST_L_M2:
            begin
                raddr    = q_reg;
                nx_we    = 1'b1;
                nx_waddr = hdr_reg;
                nx_wdata = pn_c;
                sz_we    = merge_up;
                sz_waddr = hdr_reg;
                sz_wdata = newsz_c;
            end
            ST_L_M3:
            begin
                nx_we    = 1'b1;
                nx_waddr = q_reg;
                nx_wdata = merge_dn ? pn_reg : hdr_reg;
                sz_we    = merge_dn;
                sz_waddr = q_reg;
                sz_wdata = siz_rd + newsz_reg;
            end
            ST_L_RET:
            begin
                raddr = rover_reg;
            end
            default:
            begin
                raddr = q_reg;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            rover_reg   <= '0;
            started_reg <= 1'b0;
            brk_reg     <= ADDR_W'(1);
            limit_reg   <= LIMIT_RESET;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            rover_reg   <= rover_next;
            started_reg <= started_next;
            brk_reg     <= brk_next;
            done_reg    <= done_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    // walk payload
    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        units_reg  <= units_next;
        q_reg      <= q_next;
        p_reg      <= p_next;
        pc_reg     <= pc_next;
        hdr_reg    <= hdr_next;
        qn_reg     <= qn_next;
        szqn_reg   <= szqn_next;
        nqn_reg    <= nqn_next;
        newsz_reg  <= newsz_next;
        pn_reg     <= pn_next;
        steps_reg  <= steps_next;
        lsteps_reg <= lsteps_next;
        grow_reg   <= grow_next;
        daddr_reg  <= daddr_next;
        stat_reg   <= stat_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign data_address = daddr_reg;
    assign status       = stat_reg;

endmodule
`default_nettype wire

/* verif/tb_next_fit_free_list_allocator.sv */
`default_nettype none
module tb_next_fit_free_list_allocator;
    import nfa_pkg::*;

    typedef struct packed {
        logic [ADDR_W-1:0] data_address;
        logic              status;
    } reply_t;

    logic              clk;
    logic              rst_n;
    logic              start;
    logic              busy;
    logic              action;
    logic [15:0]       byte_count;
    logic [ADDR_W-1:0] block_address;
    logic              done;
    logic [ADDR_W-1:0] data_address;
    logic              status;
    logic              cfg_we;
    logic [ADDR_W-1:0] cfg_wdata;

    // shadow heap state
    logic [ADDR_W-1:0] shadow_next [HEAP_UNITS];
    logic [ADDR_W-1:0] shadow_size [HEAP_UNITS];
    int                shadow_rover;
    bit                shadow_started;
    int                shadow_break;
    int                shadow_limit;

    reply_t            pending_replies [$];
    int                live_blocks [$];
    int                mismatches;
    int                gap_pct;

    next_fit_free_list_allocator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .action        (action),
        .byte_count    (byte_count),
        .block_address (block_address),
        .done          (done),
        .data_address  (data_address),
        .status        (status),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #20000000;
        $display("Mismatches found");
        $finish;
    end

    function automatic void heap_start();
        if (!shadow_started)
        begin
            shadow_next[0] = '0;
            shadow_size[0] = '0;
            shadow_rover = 0;
            shadow_started = 1'b1;
        end
    endfunction

    // link a header back into the address-ordered ring, merging neighbours
    function automatic void heap_link(int hdr);
        int q;
        int qn;
        int pn;
        int steps;
        q = shadow_rover;
        steps = 0;
        forever
        begin
            qn = shadow_next[q];
            if (hdr > q && hdr < qn)
                break;
            if (q >= qn && (hdr > q || hdr < qn))
                break;
            q = qn;
            steps++;
            if (steps > WALK_LIMIT)
                return;
        end
        qn = shadow_next[q];
        if (hdr + shadow_size[hdr] == qn)
        begin
            shadow_size[hdr] = 12'(shadow_size[hdr] + shadow_size[qn]);
            shadow_next[hdr] = shadow_next[qn];
        end
        else
            shadow_next[hdr] = 12'(qn);
        pn = shadow_next[hdr];
        if (q + shadow_size[q] == hdr)
        begin
            shadow_size[q] = 12'(shadow_size[q] + shadow_size[hdr]);
            shadow_next[q] = 12'(pn);
        end
        else
            shadow_next[q] = 12'(hdr);
        shadow_rover = q;
    endfunction

    function automatic bit heap_grow(int units);
        int amount;
        int top;
        int hdr;
        amount = ((units + GROW_CHUNK - 1) / GROW_CHUNK) * GROW_CHUNK;
        top = shadow_break + amount;
        if (top > shadow_limit || top > HEAP_UNITS)
            return 1'b0;
        hdr = shadow_break;
        shadow_size[hdr] = 12'(amount);
        shadow_break = top & 12'hfff;
        heap_link(hdr);
        return 1'b1;
    endfunction

    // next-fit search; returns data unit or 0 when out of memory
    function automatic int heap_allocate(int bytes);
        int units;
        int q;
        int p;
        int sz;
        int steps;
        units = 1 + (bytes + UNIT_BYTES - 1) / UNIT_BYTES;
        steps = 0;
        heap_start();
        q = shadow_rover;
        p = shadow_next[q];
        forever
        begin
            sz = shadow_size[p];
            if (sz >= units)
            begin
                if (sz == units)
                    shadow_next[q] = shadow_next[p];
                else
                begin
                    sz = sz - units;
                    shadow_size[p] = 12'(sz);
                    p = p + sz;
                    shadow_size[p] = 12'(units);
                end
                shadow_rover = q;
                return (p + 1) & 12'hfff;
            end
            if (p == shadow_rover)
            begin
                if (!heap_grow(units))
                    return 0;
                p = shadow_rover;
            end
            q = p;
            p = shadow_next[p];
            steps++;
            if (steps > WALK_LIMIT)
                return 0;
        end
    endfunction

    // check each result beat against the oldest prediction
    always @(posedge clk)
    begin
        reply_t exp_r;
        if (rst_n && done)
        begin
            if (pending_replies.size() == 0)
            begin
                $error("result beat with nothing expected");
                mismatches++;
            end
            else
            begin
                exp_r = pending_replies.pop_front();
                if (data_address !== exp_r.data_address)
                begin
                    $error("data_address expected %0d actual %0d",
                           exp_r.data_address, data_address);
                    mismatches++;
                end
                if (status !== exp_r.status)
                begin
                    $error("status expected %0d actual %0d", exp_r.status, status);
                    mismatches++;
                end
            end
        end
    end

    // present one request, hold until accepted, predict, then idle at random
    task automatic send_request(logic act, logic [15:0] bytes, logic [ADDR_W-1:0] addr);
        reply_t r;
        int gap;
        start <= 1'b1;
        action <= act;
        byte_count <= bytes;
        block_address <= addr;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        r.data_address = '0;
        r.status = STAT_DONE;
        if (act == ACT_ALLOC)
        begin
            r.data_address = 12'(heap_allocate(bytes));
            if (r.data_address == 0)
                r.status = STAT_OOM;
            else
                live_blocks.push_back(r.data_address);
        end
        else
        begin
            heap_start();
            heap_link((addr - 1) & 12'hfff);
        end
        pending_replies.push_back(r);
        if ($urandom_range(99) < gap_pct)
        begin
            gap = $urandom_range(12, 1);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic alloc_bytes(int bytes);
        send_request(ACT_ALLOC, 16'(bytes), 12'($urandom));
    endtask

    // free a live block picked at index idx
    task automatic free_live(int idx);
        int addr;
        addr = live_blocks[idx];
        live_blocks.delete(idx);
        send_request(ACT_FREE, 16'($urandom), 12'(addr));
    endtask

    // hold off until every expected result has come
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    task automatic write_limit(int value);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= 12'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        shadow_limit = value & 12'hfff;
    endtask

    task automatic test_directed();
        gap_pct = 0;
        alloc_bytes(0);
        alloc_bytes(65535);
        alloc_bytes(1);
        alloc_bytes(4);
        alloc_bytes(5);
        alloc_bytes(8);
        free_live(2);
        free_live(1);
        alloc_bytes(12);
        alloc_bytes(1020);
        alloc_bytes(16380);
        free_live(0);
        free_live(0);
        alloc_bytes(7);
        free_live(live_blocks.size() - 1);
        drain();
    endtask

    task automatic test_limit_extremes();
        write_limit(0);
        alloc_bytes(2000);
        alloc_bytes(0);
        free_live(0);
        alloc_bytes(3);
        write_limit(shadow_break + 256);
        alloc_bytes(1500);
        alloc_bytes(200);
        write_limit(4095);
        alloc_bytes(15000);
        alloc_bytes(65535);
        while (live_blocks.size() > 0)
            free_live($urandom_range(live_blocks.size() - 1));
        drain();
    endtask

    task automatic run_random(int count, int gap);
        int pick;
        gap_pct = gap;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            if (live_blocks.size() > 0 && (pick < 45 || live_blocks.size() > 40))
                free_live($urandom_range(live_blocks.size() - 1));
            else if (pick < 80)
                alloc_bytes($urandom_range(64));
            else if (pick < 97)
                alloc_bytes($urandom_range(1500, 65));
            else
                alloc_bytes($urandom_range(65535));
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        action = ACT_ALLOC;
        byte_count = '0;
        block_address = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        mismatches = 0;
        gap_pct = 0;
        shadow_rover = 0;
        shadow_started = 1'b0;
        shadow_break = 1;
        shadow_limit = LIMIT_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_limit_extremes();
        run_random(320, 0);
        write_limit($urandom_range(3000, 1200));
        run_random(320, 60);
        write_limit(4095);
        run_random(320, 7);
        write_limit($urandom_range(4095));
        run_random(300, 30);

        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
`default_nettype wire
